@@ rtl/core/lospp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lospp_pkg: shared types and constants of the line-of-sight path pruner
// Coordinate widths, table geometry, command codes and channel payloads.
// ----------------------------------------------------------------------------
package lospp_pkg;

  localparam int MAX_LINES  = 64;
  localparam int COORD_BITS = 16;

  localparam int LINE_AW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int CNT_W   = $clog2(MAX_LINES + 1);
  localparam int CFG_W   = 7;
  localparam int SLOT_W  = 6;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_POINT = 1'b1;

  typedef logic signed [COORD_BITS-1:0]   coord_t;
  typedef logic signed [COORD_BITS:0]     diff_t;
  typedef logic signed [2*COORD_BITS+1:0] prod_t;
  typedef logic signed [2*COORD_BITS+2:0] sum_t;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
  } line_t;

  typedef struct packed {
    logic              command;
    logic [SLOT_W-1:0] line_index;
    coord_t            line_ax;
    coord_t            line_ay;
    coord_t            line_bx;
    coord_t            line_by;
    coord_t            point_x;
    coord_t            point_y;
    logic              path_start;
    logic              path_end;
  } cmd_t;

  typedef struct packed {
    coord_t way_x;
    coord_t way_y;
    logic   way_last;
  } way_t;

  typedef struct packed {
    logic [CFG_W-1:0] line_count;
  } cfg_t;

endpackage
`default_nettype wire

@@ rtl/core/lospp_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lospp_if: valid/ready channels of the line-of-sight path pruner
// One interface per channel: command beats, waypoint beats and the register.
// ----------------------------------------------------------------------------
interface lospp_cmd_if;
  import lospp_pkg::*;
  logic valid;
  logic ready;
  cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lospp_way_if;
  import lospp_pkg::*;
  logic valid;
  logic ready;
  way_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lospp_cfg_if;
  import lospp_pkg::*;
  logic valid;
  logic ready;
  cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/path_line_of_sight_pruner_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// path_line_of_sight_pruner_top: line-of-sight path pruner
// Holds obstacle segments in a table memory and thins a stream of path points
// into waypoints using an exact integer segment intersection test.
// ----------------------------------------------------------------------------
// Usage:
// The cmd channel carries one beat per command. A load beat writes one
// obstacle segment into the table. A point beat either starts a path
// (emitted at once, no test) or is tested against table slots 0 to
// line_count-1, clamped to the table depth.
// The test reads one table entry per cycle from the single read port of the
// table memory and feeds a three-stage arithmetic pipeline; the cmd channel
// stays blocked during the scan and until the waypoints a point queues have
// moved into the output register. Points are handled one at a time.
// The way channel delivers zero, one or two waypoint beats per point. The
// output register decouples the sides: a new command is accepted while the
// last waypoint still waits there, but not while a second result is pending.
// When the receiver stalls, the waypoint holds and cmd.ready stays low once a
// further result is queued behind it.
// The cfg channel writes line_count and is always ready; the user must write
// it only while the block is idle, which the block itself does not enforce.
// Reset clears line_count, the anchor and previous point and all control
// state. The table has no reset; slots must be loaded before they are tested.
// ----------------------------------------------------------------------------
module path_line_of_sight_pruner_top (
  input  wire logic clk,
  input  wire logic rst,
  lospp_cfg_if.sink cfg,
  lospp_cmd_if.sink cmd,
  lospp_way_if.source way
);
  import lospp_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  // Obstacle table, one segment per entry, registered read.
  line_t line_mem [MAX_LINES];
  line_t rd_line;

  logic [0:0]       state;
  logic [CNT_W-1:0] line_n;
  logic [CNT_W-1:0] rd_idx;
  logic             rd_en;
  logic             rd_v;
  logic             va;
  logic             vb;
  logic             vc;
  logic             hit;

  coord_t anchor_x;
  coord_t anchor_y;
  coord_t prev_x;
  coord_t prev_y;
  coord_t cur_x;
  coord_t cur_y;
  logic   cur_end;
  diff_t  s1x;
  diff_t  s1y;

  // Pending results: the first is a kept point with way_last low, the second
  // is the current point closing the path.
  logic   pend_a;
  logic   pend_b;
  coord_t hold_x;
  coord_t hold_y;

  logic   way_valid;
  way_t   way_data;
  logic   out_free;

  diff_t  s2x;
  diff_t  s2y;
  diff_t  d0x;
  diff_t  d0y;
  prod_t  p_den_a;
  prod_t  p_den_b;
  prod_t  p_sn_a;
  prod_t  p_sn_b;
  prod_t  p_tn_a;
  prod_t  p_tn_b;
  sum_t   den;
  sum_t   sn;
  sum_t   tn;

  logic   line_hit;
  logic   den_pos;
  logic   s_ok;
  logic   t_ok;
  logic   cmd_acc;
  logic   scan_done;

  assign cfg.ready = 1'b1;
  assign cmd.ready = (state == ST_IDLE) && !pend_a && !pend_b;
  assign cmd_acc   = cmd.valid && cmd.ready;
  assign way.valid = way_valid;
  assign way.data  = way_data;
  assign out_free  = !way_valid || way.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_n <= '0;
    end else if (cfg.valid && cfg.ready) begin
      if (int'(cfg.data.line_count) > MAX_LINES) begin
        line_n <= CNT_W'(MAX_LINES);
      end else begin
        line_n <= CNT_W'(cfg.data.line_count);
      end
    end
  end

  // Table write on a load beat; slots beyond the table are dropped.
  always_ff @(posedge clk) begin
    if (cmd_acc && cmd.data.command == CMD_LOAD &&
        int'(cmd.data.line_index) < MAX_LINES) begin
      line_mem[LINE_AW'(cmd.data.line_index)] <= '{ax: cmd.data.line_ax,
                                                   ay: cmd.data.line_ay,
                                                   bx: cmd.data.line_bx,
                                                   by: cmd.data.line_by};
    end
  end

  assign rd_en = (state == ST_SCAN) && (rd_idx < line_n);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_line <= line_mem[rd_idx[LINE_AW-1:0]];
    end
  end

  // Arithmetic pipeline: differences, six products, three sums, compare.
  always_ff @(posedge clk) begin
    s2x <= diff_t'(rd_line.bx) - diff_t'(rd_line.ax);
    s2y <= diff_t'(rd_line.by) - diff_t'(rd_line.ay);
    d0x <= diff_t'(anchor_x) - diff_t'(rd_line.ax);
    d0y <= diff_t'(anchor_y) - diff_t'(rd_line.ay);

    p_den_a <= s1x * s2y;
    p_den_b <= s2x * s1y;
    p_sn_a  <= s1x * d0y;
    p_sn_b  <= s1y * d0x;
    p_tn_a  <= s2x * d0y;
    p_tn_b  <= s2y * d0x;

    den <= sum_t'(p_den_a) - sum_t'(p_den_b);
    sn  <= sum_t'(p_sn_a) - sum_t'(p_sn_b);
    tn  <= sum_t'(p_tn_a) - sum_t'(p_tn_b);
  end

  // s/den must lie in the closed unit interval, t/den in the open one.
  always_comb begin
    den_pos = !den[$high(den)];
    if (den_pos) begin
      s_ok = !sn[$high(sn)] && (sn <= den);
      t_ok = !tn[$high(tn)] && (tn != '0) && (tn < den);
    end else begin
      s_ok = (sn[$high(sn)] || sn == '0) && (sn >= den);
      t_ok = tn[$high(tn)] && (tn > den);
    end
    line_hit = (den != '0) && s_ok && t_ok;
  end

  assign scan_done = (state == ST_SCAN) && !rd_en && !rd_v && !va && !vb && !vc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rd_idx   <= '0;
      rd_v     <= 1'b0;
      va       <= 1'b0;
      vb       <= 1'b0;
      vc       <= 1'b0;
      hit      <= 1'b0;
      anchor_x <= '0;
      anchor_y <= '0;
      prev_x   <= '0;
      prev_y   <= '0;
      pend_a   <= 1'b0;
      pend_b   <= 1'b0;
      way_valid <= 1'b0;
    end else begin
      rd_v <= rd_en;
      va   <= rd_v;
      vb   <= va;
      vc   <= vb;
      if (vc && line_hit) begin
        hit <= 1'b1;
      end
      if (rd_en) begin
        rd_idx <= rd_idx + CNT_W'(1);
      end

      // Drain pending results into the output register.
      if (out_free) begin
        if (pend_a) begin
          way_data  <= '{way_x: hold_x, way_y: hold_y, way_last: 1'b0};
          way_valid <= 1'b1;
          pend_a    <= 1'b0;
        end else if (pend_b) begin
          way_data  <= '{way_x: cur_x, way_y: cur_y, way_last: 1'b1};
          way_valid <= 1'b1;
          pend_b    <= 1'b0;
        end else begin
          way_valid <= 1'b0;
        end
      end

      unique case (state)
        ST_IDLE: begin
          if (cmd_acc && cmd.data.command == CMD_POINT) begin
            cur_x   <= cmd.data.point_x;
            cur_y   <= cmd.data.point_y;
            cur_end <= cmd.data.path_end;
            if (cmd.data.path_start) begin
              hold_x   <= cmd.data.point_x;
              hold_y   <= cmd.data.point_y;
              pend_a   <= 1'b1;
              pend_b   <= cmd.data.path_end;
              anchor_x <= cmd.data.point_x;
              anchor_y <= cmd.data.point_y;
              prev_x   <= cmd.data.point_x;
              prev_y   <= cmd.data.point_y;
            end else begin
              s1x    <= diff_t'(cmd.data.point_x) - diff_t'(anchor_x);
              s1y    <= diff_t'(cmd.data.point_y) - diff_t'(anchor_y);
              rd_idx <= '0;
              hit    <= 1'b0;
              state  <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            if (hit) begin
              hold_x   <= prev_x;
              hold_y   <= prev_y;
              pend_a   <= 1'b1;
              anchor_x <= prev_x;
              anchor_y <= prev_y;
            end
            pend_b <= cur_end;
            prev_x <= cur_x;
            prev_y <= cur_y;
            state  <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The test pipeline is empty whenever the block waits for a command.
  a_pipe_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !(rd_v || va || vb || vc))
    else $error("test pipeline busy outside a scan");

  // Results of the previous point are queued out before a scan starts.
  a_no_pend_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (!pend_a && !pend_b))
    else $error("pending result during a scan");

  // The read index never runs past the loaded line count.
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (rd_idx <= line_n))
    else $error("table read index beyond line count");

  // A first queued result only appears after a scan or an accepted command.
  a_pend_order: assert property (@(posedge clk) disable iff (rst)
    $rose(pend_a) |-> $past(state == ST_SCAN || cmd_acc))
    else $error("result queued without a point");

endmodule
`default_nettype wire
